// ----- sv/hsv_to_rgb_converter_assert.svh -----
// assertion macros for the hsv to rgb converter
`ifndef HSV_TO_RGB_CONVERTER_ASSERT_SVH
`define HSV_TO_RGB_CONVERTER_ASSERT_SVH
`ifndef SYNTHESIS
// checked outside reset
`define HSV_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define HSV_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HSV_ASSERT(name, prop, msg)
`define HSV_ASSERT_ALWAYS(name, prop, msg)
`endif
`endif

// ----- sv/hsv_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package hsv_pkg;

  // configuration port
  localparam int CFG_AW = 3;
  localparam logic REG_HUE_WARP = 1'b0;

  // color sextant codes
  localparam logic [2:0] SECT_RED_YEL = 3'd0;
  localparam logic [2:0] SECT_YEL_GRN = 3'd1;
  localparam logic [2:0] SECT_GRN_CYN = 3'd2;
  localparam logic [2:0] SECT_CYN_BLU = 3'd3;
  localparam logic [2:0] SECT_BLU_MAG = 3'd4;
  localparam logic [2:0] SECT_MAG_RED = 3'd5;

  localparam int WARP_DIV = 384;

  typedef logic [255:0][7:0] warp_rom_t;

  typedef struct packed {
    logic [7:0] hue;
    logic [7:0] sat;
    logic [7:0] val;
  } hsv_pix_t;

  typedef struct packed {
    logic [2:0] sect;
    logic [7:0] frac;
    logic [7:0] sat;
    logic [7:0] val;
  } hsv_sect_t;

  typedef struct packed {
    logic [2:0] sect;
    logic       grey;
    logic [7:0] val;
    logic [7:0] p;
    logic [7:0] q_arg;
    logic [7:0] t_arg;
  } hsv_prod_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } hsv_rgb_t;

  // hue warp table: quarter circle then squared inside each sixth,
  // mirrored on odd sixths, truncated
  function automatic warp_rom_t warp_rom_build();
    warp_rom_t rom;
    int u;
    int w;
    int k;
    int g;
    for (int h = 0; h < 256; h++) begin
      u = 3 * h;
      w = u / 128;
      k = u % 128;
      g = ((w % 2) == 1) ? k * k : k * (256 - k);
      rom[h] = 8'((16384 * w + g) / WARP_DIV);
    end
    return rom;
  endfunction

  localparam warp_rom_t WARP_ROM = warp_rom_build();

endpackage
`default_nettype wire

// ----- sv/hsv_warp.sv -----
`timescale 1ns / 1ps
`default_nettype none
module hsv_warp
  import hsv_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     warp_en,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire hsv_pix_t in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output hsv_pix_t      out_data
);

  logic     valid_r;
  hsv_pix_t data_r;
  hsv_pix_t data_nxt;

  assign in_ready = !valid_r || out_ready;

  // optional hue remap through the table
  always_comb begin
    data_nxt = in_data;
    if (warp_en) begin
      data_nxt.hue = WARP_ROM[in_data.hue];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule
`default_nettype wire

// ----- sv/hsv_sector.sv -----
`timescale 1ns / 1ps
`default_nettype none
module hsv_sector
  import hsv_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire hsv_pix_t in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output hsv_sect_t     out_data
);

  logic      valid_r;
  hsv_sect_t data_r;
  hsv_sect_t data_nxt;
  logic [7:0] base;
  logic [5:0] rem;

  assign in_ready = !valid_r || out_ready;

  // sextant by compare against multiples of 43, remainder scaled by 6
  always_comb begin
    if (in_data.hue >= 8'd215) begin
      data_nxt.sect = SECT_MAG_RED;
      base          = 8'd215;
    end else if (in_data.hue >= 8'd172) begin
      data_nxt.sect = SECT_BLU_MAG;
      base          = 8'd172;
    end else if (in_data.hue >= 8'd129) begin
      data_nxt.sect = SECT_CYN_BLU;
      base          = 8'd129;
    end else if (in_data.hue >= 8'd86) begin
      data_nxt.sect = SECT_GRN_CYN;
      base          = 8'd86;
    end else if (in_data.hue >= 8'd43) begin
      data_nxt.sect = SECT_YEL_GRN;
      base          = 8'd43;
    end else begin
      data_nxt.sect = SECT_RED_YEL;
      base          = 8'd0;
    end
    rem           = 6'(in_data.hue - base);
    data_nxt.frac = {rem, 2'b00} + {1'b0, rem, 1'b0};
    data_nxt.sat  = in_data.sat;
    data_nxt.val  = in_data.val;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule
`default_nettype wire

// ----- sv/hsv_prod.sv -----
`timescale 1ns / 1ps
`default_nettype none
module hsv_prod
  import hsv_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire hsv_sect_t in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output hsv_prod_t      out_data
);

  logic      valid_r;
  hsv_prod_t data_r;
  hsv_prod_t data_nxt;
  logic [15:0] p_full;
  logic [15:0] sf_full;
  logic [15:0] sfc_full;

  assign in_ready = !valid_r || out_ready;

  // three parallel 8x8 products
  always_comb begin
    p_full   = 16'(in_data.val) * 16'(8'd255 - in_data.sat);
    sf_full  = 16'(in_data.sat) * 16'(in_data.frac);
    sfc_full = 16'(in_data.sat) * 16'(8'd255 - in_data.frac);
    data_nxt.sect  = in_data.sect;
    data_nxt.grey  = (in_data.sat == 8'd0);
    data_nxt.val   = in_data.val;
    data_nxt.p     = p_full[15:8];
    data_nxt.q_arg = sf_full[15:8];
    data_nxt.t_arg = sfc_full[15:8];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule
`default_nettype wire

// ----- sv/hsv_mix.sv -----
`timescale 1ns / 1ps
`default_nettype none
module hsv_mix
  import hsv_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire hsv_prod_t in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output hsv_rgb_t       out_data
);

  logic       valid_r;
  hsv_rgb_t   data_r;
  hsv_rgb_t   data_nxt;
  logic [15:0] q_full;
  logic [15:0] t_full;
  logic [7:0] v;
  logic [7:0] p;
  logic [7:0] q;
  logic [7:0] t;

  assign in_ready = !valid_r || out_ready;

  // q and t products, then channel routing per sextant
  always_comb begin
    v      = in_data.val;
    p      = in_data.p;
    q_full = 16'(in_data.val) * 16'(8'd255 - in_data.q_arg);
    t_full = 16'(in_data.val) * 16'(8'd255 - in_data.t_arg);
    q      = q_full[15:8];
    t      = t_full[15:8];
    case (in_data.sect)
      SECT_RED_YEL: data_nxt = '{red: v, green: t, blue: p};
      SECT_YEL_GRN: data_nxt = '{red: q, green: v, blue: p};
      SECT_GRN_CYN: data_nxt = '{red: p, green: v, blue: t};
      SECT_CYN_BLU: data_nxt = '{red: p, green: q, blue: v};
      SECT_BLU_MAG: data_nxt = '{red: t, green: p, blue: v};
      default:      data_nxt = '{red: v, green: p, blue: q};
    endcase
    // zero saturation is grey
    if (in_data.grey) begin
      data_nxt = '{red: v, green: v, blue: v};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule
`default_nettype wire

// ----- sv/hsv_to_rgb_converter.sv -----
// an accepted request passes the warp, sector, product and mix registers before its result shows on out_tvalid
// throughput: one pixel per cycle while out_tready holds, four register stages each with its own valid bit
// each stage takes a new request while it is empty or its successor takes its own
// reset is a synchronous active-low rst_n that clears all stage valid bits and warp_en_r
`timescale 1ns / 1ps
`default_nettype none
`include "hsv_to_rgb_converter_assert.svh"
module hsv_to_rgb_converter
  import hsv_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [23:0]       in_tdata,   // hue, saturation, brightness
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [23:0]            out_tdata,  // red, green, blue
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [CFG_AW-1:0] cfg_paddr,
  input  wire logic [31:0]       cfg_pwdata,
  output logic [31:0]            cfg_prdata,
  output logic                   cfg_pready
);

  logic      warp_en_r;
  logic      cfg_wr;
  hsv_pix_t  in_pix;
  logic      w_valid;
  logic      w_ready;
  hsv_pix_t  w_data;
  logic      s_valid;
  logic      s_ready;
  hsv_sect_t s_data;
  logic      p_valid;
  logic      p_ready;
  hsv_prod_t p_data;
  hsv_rgb_t  rgb;

  // configuration register
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                      && (cfg_paddr[2] == REG_HUE_WARP);
  assign cfg_prdata = (cfg_paddr[2] == REG_HUE_WARP) ? {31'd0, warp_en_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      warp_en_r <= 1'b0;
    end else if (cfg_wr) begin
      warp_en_r <= cfg_pwdata[0];
    end
  end

  // input unpacking
  assign in_pix.hue = in_tdata[7:0];
  assign in_pix.sat = in_tdata[15:8];
  assign in_pix.val = in_tdata[23:16];

  hsv_warp u_warp (
    .clk       (clk),
    .rst_n     (rst_n),
    .warp_en   (warp_en_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_data   (in_pix),
    .out_valid (w_valid),
    .out_ready (w_ready),
    .out_data  (w_data)
  );

  hsv_sector u_sector (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (w_valid),
    .in_ready  (w_ready),
    .in_data   (w_data),
    .out_valid (s_valid),
    .out_ready (s_ready),
    .out_data  (s_data)
  );

  hsv_prod u_prod (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s_valid),
    .in_ready  (s_ready),
    .in_data   (s_data),
    .out_valid (p_valid),
    .out_ready (p_ready),
    .out_data  (p_data)
  );

  hsv_mix u_mix (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (p_valid),
    .in_ready  (p_ready),
    .in_data   (p_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (rgb)
  );

  // output packing
  assign out_tdata = {rgb.blue, rgb.green, rgb.red};

  // checks
  `HSV_ASSERT_ALWAYS(a_reset_empties, !rst_n |=> !out_tvalid, "output valid after reset")
  `HSV_ASSERT(a_empty_out_ready, !out_tvalid |-> in_tready, "input stalled with empty output")
  `HSV_ASSERT(a_cfg_write, cfg_wr |=> (warp_en_r == $past(cfg_pwdata[0])), "warp enable not written")

endmodule
`default_nettype wire

// ----- test/tb.sv -----
`timescale 1ns / 1ps
module tb;
  import hsv_pkg::*;

  localparam int LATENCY     = 4;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_RUN  = 170;
  localparam int REG_SPARE   = 1;
  localparam logic [CFG_AW-1:0] ADDR_HUE_WARP = CFG_AW'(4 * REG_HUE_WARP);
  localparam logic [CFG_AW-1:0] ADDR_SPARE    = CFG_AW'(4 * REG_SPARE);

  // expected colors and the hue warp setting they depend on
  class pixel_board;
    bit         warp_on;
    hsv_rgb_t   expected_rgb[$];
    int         mismatches;
    int         results;
    int         grey_requests;
    int         warped_requests;

    function new();
      warp_on = 1'b0;
      mismatches = 0;
      results = 0;
      grey_requests = 0;
      warped_requests = 0;
    endfunction

    // register index other than the warp enable is dropped, only bit 0 is kept
    function void set_register(int unsigned idx, logic [31:0] data);
      if (idx == REG_HUE_WARP) begin
        warp_on = data[0];
      end
    endfunction

    // bend the hue within its sixth: quarter circle squared, mirrored on odd sixths
    function logic [7:0] bend_hue(logic [7:0] h);
      int unsigned scaled;
      int unsigned sixth;
      int unsigned pos;
      int unsigned curve;
      scaled = 3 * h;
      sixth = scaled >> 7;
      pos = scaled & 127;
      curve = sixth[0] ? pos * pos : pos * (256 - pos);
      return 8'((16384 * sixth + curve) / WARP_DIV);
    endfunction

    function hsv_rgb_t predict_rgb(hsv_pix_t px);
      hsv_rgb_t    rgb;
      int unsigned h;
      int unsigned s;
      int unsigned v;
      int unsigned sect;
      int unsigned frac;
      logic [7:0]  p;
      logic [7:0]  q;
      logic [7:0]  t;
      h = px.hue;
      s = px.sat;
      v = px.val;
      // grey ignores hue and warp
      if (s == 0) begin
        rgb.red = px.val;
        rgb.green = px.val;
        rgb.blue = px.val;
        return rgb;
      end
      if (warp_on) begin
        h = bend_hue(px.hue);
      end
      sect = h / 43;
      frac = (h - sect * 43) * 6;
      p = 8'((v * (255 - s)) >> 8);
      q = 8'((v * (255 - ((s * frac) >> 8))) >> 8);
      t = 8'((v * (255 - ((s * (255 - frac)) >> 8))) >> 8);
      case (3'(sect))
        SECT_RED_YEL: begin rgb.red = px.val; rgb.green = t; rgb.blue = p; end
        SECT_YEL_GRN: begin rgb.red = q; rgb.green = px.val; rgb.blue = p; end
        SECT_GRN_CYN: begin rgb.red = p; rgb.green = px.val; rgb.blue = t; end
        SECT_CYN_BLU: begin rgb.red = p; rgb.green = q; rgb.blue = px.val; end
        SECT_BLU_MAG: begin rgb.red = t; rgb.green = p; rgb.blue = px.val; end
        default:      begin rgb.red = px.val; rgb.green = p; rgb.blue = q; end
      endcase
      return rgb;
    endfunction

    function void note_pixel(hsv_pix_t px);
      if (px.sat == 8'd0) grey_requests++;
      else if (warp_on) warped_requests++;
      expected_rgb.push_back(predict_rgb(px));
    endfunction

    function void check_pixel(hsv_rgb_t got);
      hsv_rgb_t want;
      results++;
      if (expected_rgb.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: unexpected color r=%0d g=%0d b=%0d",
                   results, got.red, got.green, got.blue);
        return;
      end
      want = expected_rgb.pop_front();
      if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                   results, want.red, want.green, want.blue,
                   got.red, got.green, got.blue);
      end
    endfunction

    function int pending();
      return expected_rgb.size();
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [23:0]       in_tdata = '0;   // hue, saturation, brightness
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [23:0]       out_tdata;       // red, green, blue
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [31:0]       cfg_pwdata = '0;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;

  pixel_board board;
  int         cycles = 0;
  int         sent = 0;
  int         hold_left = 0;
  hsv_rgb_t   seen_rgb;

  hsv_to_rgb_converter u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #6 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // result side: take a color, then stall for a drawn number of cycles
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left = 0;
    end else if (out_tready && out_tvalid) begin
      seen_rgb.red = out_tdata[7:0];
      seen_rgb.green = out_tdata[15:8];
      seen_rgb.blue = out_tdata[23:16];
      board.check_pixel(seen_rgb);
      hold_left = (board.results % 64 < 16) ? 0 : $urandom_range(0, 6);
      out_tready <= (hold_left == 0);
    end else if (!out_tready) begin
      if (hold_left > 0) hold_left--;
      if (hold_left == 0) out_tready <= 1'b1;
    end
  end

  // one request, with a drawn idle gap ahead of it
  task automatic send_pixel(input logic [7:0] h, input logic [7:0] s, input logic [7:0] v);
    hsv_pix_t px;
    int       gap;
    px.hue = h;
    px.sat = s;
    px.val = v;
    gap = (sent % 64 < 16) ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {v, s, h};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_pixel(px);
    sent++;
  endtask

  // random request, saturation and brightness lean toward their extremes
  task automatic send_random_pixel();
    logic [7:0] s;
    logic [7:0] v;
    case ($urandom_range(0, 15))
      0:       s = 8'd0;
      1:       s = 8'd255;
      default: s = 8'($urandom_range(0, 255));
    endcase
    case ($urandom_range(0, 15))
      0:       v = 8'd0;
      1:       v = 8'd255;
      default: v = 8'($urandom_range(0, 255));
    endcase
    send_pixel(8'($urandom_range(0, 255)), s, v);
  endtask

  // hold off until every expected color is back and the pipe is empty
  task automatic drain();
    in_tvalid <= 1'b0;
    while (board.pending() > 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_AW-1:0] addr, input logic [31:0] data);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    board.set_register(addr / 4, data);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  initial begin
    board = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // plain conversion: region edges, extremes, grey
    send_pixel(8'd0,   8'd255, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd42,  8'd255, 8'd255);
    send_pixel(8'd43,  8'd255, 8'd255);
    send_pixel(8'd85,  8'd200, 8'd180);
    send_pixel(8'd86,  8'd200, 8'd180);
    send_pixel(8'd128, 8'd255, 8'd255);
    send_pixel(8'd129, 8'd255, 8'd128);
    send_pixel(8'd171, 8'd255, 8'd255);
    send_pixel(8'd172, 8'd90,  8'd255);
    send_pixel(8'd214, 8'd255, 8'd255);
    send_pixel(8'd215, 8'd255, 8'd255);
    send_pixel(8'd230, 8'd128, 8'd77);
    send_pixel(8'd100, 8'd0,   8'd200);
    send_pixel(8'd37,  8'd0,   8'd0);
    send_pixel(8'd255, 8'd0,   8'd255);
    send_pixel(8'd0,   8'd1,   8'd255);
    send_pixel(8'd128, 8'd255, 8'd0);
    send_pixel(8'd200, 8'd1,   8'd1);
    drain();

    // warped hue: sixth boundaries and exact table points, then random pixels
    cfg_write(ADDR_HUE_WARP, 32'd1);
    send_pixel(8'd0,   8'd255, 8'd255);
    send_pixel(8'd42,  8'd255, 8'd255);
    send_pixel(8'd43,  8'd255, 8'd255);
    send_pixel(8'd128, 8'd255, 8'd255);
    send_pixel(8'd170, 8'd255, 8'd255);
    send_pixel(8'd213, 8'd180, 8'd240);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd77,  8'd0,   8'd99);
    repeat (RANDOM_RUN) send_random_pixel();
    drain();

    // write to a spare address must leave the warp on
    cfg_write(ADDR_SPARE, 32'h0000_0000);
    repeat (RANDOM_RUN) send_random_pixel();
    drain();

    // only bit 0 counts
    cfg_write(ADDR_HUE_WARP, 32'hFFFF_FFFE);
    repeat (RANDOM_RUN) send_random_pixel();
    drain();

    cfg_write(ADDR_HUE_WARP, 32'hFFFF_FFFF);
    repeat (RANDOM_RUN) send_random_pixel();
    drain();

    $display("converted %0d pixels: %0d grey, %0d through the hue warp, %0d mismatches",
             board.results, board.grey_requests, board.warped_requests, board.mismatches);
    $display("warp toggled on and off, spare register write and upper data bits exercised");
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- hsv_to_rgb_converter.f -----
+incdir+sv
sv/hsv_pkg.sv
sv/hsv_warp.sv
sv/hsv_sector.sv
sv/hsv_prod.sv
sv/hsv_mix.sv
sv/hsv_to_rgb_converter.sv
test/tb.sv
